// ----- rtl/sld_pkg.sv -----
// Shared types and constants for the sync/length deframer.
// No dependencies; imported by every module of the block.
package sld_pkg;

    localparam int unsigned MAX_FRAME = 32;
    localparam int unsigned LEN_W     = 6;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(32);
    localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(MAX_FRAME);

    // Register index of the maximum payload length register.
    localparam logic REG_MAX_LEN = 1'b0;

    // One result item handed from the parser to the output stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
        logic              empty_frame;
    } result_t;

endpackage

// ----- rtl/sync_length_deframer.sv -----
// Top level of the sync/length deframer: config registers, parser, result register.
// Depends on sld_pkg, sld_cfg_regs, sld_parser and sld_out_reg.
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  --------------------------------------
//   in       sink       in_valid / in_stall  rx_byte
//   out      source     out_valid/out_stall  payload_byte, frame_last, empty_frame
//   apb      slave      psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// An accepted byte is registered in the input register; the framing decode then loads
// the result register from it once that register is free.
// One item can be accepted every cycle while the sink keeps up.
// Reset (rst_n low, asynchronous) returns the parser to sync hunting and empties
// both registers; the length limit returns to 32.
// A stalled output stops the input register, which then stalls the input channel.
module sync_length_deframer
    import sld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] payload_byte,
    output logic              frame_last,
    output logic              empty_frame,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [LEN_W-1:0] max_len;
    logic             out_free;
    result_t          result;

    // Software-visible limit on the payload length.
    sld_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    // Holds the incoming byte and decides, from the framing state, whether it
    // produces a payload item, an empty-frame marker, or nothing.
    sld_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .max_len  (max_len),
        .out_free (out_free),
        .result   (result)
    );

    // Result register facing the sink.
    sld_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .empty_frame  (empty_frame)
    );

endmodule

// ----- rtl/sld_cfg_regs.sv -----
// APB-style configuration register file for the deframer.
// Depends on sld_pkg for widths, register index and reset value.
module sld_cfg_regs
    import sld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [LEN_W-1:0]  max_len
);

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] max_len_next;
    logic             reg_hit;

    // Registers sit at word addresses, so the low two address bits are ignored.
    assign reg_hit = (paddr[2] == REG_MAX_LEN);

    always_comb
    begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            max_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(DATA_W-LEN_W){1'b0}}, max_len_reg} : '0;
    assign max_len = max_len_reg;

endmodule

// ----- rtl/sld_parser.sv -----
// Input register, framing state machine and result decode of the deframer.
// Depends on sld_pkg for the sync bytes, widths and the result type.
module sld_parser
    import sld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [LEN_W-1:0]  max_len,
    input  logic              out_free,
    output result_t           result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_NEED_AA,
        PH_LENGTH,
        PH_PAYLOAD
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [LEN_W-1:0]  bytes_left_reg;
    logic [LEN_W-1:0]  bytes_left_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              accept;
    logic              advance;
    logic [LEN_W-1:0]  limit;
    logic [LEN_W-1:0]  left_dec;

    // The held byte moves on whenever the output stage can take a result.
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign limit    = (max_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : max_len;
    assign left_dec = bytes_left_reg - LEN_W'(1);

    always_comb
    begin
        phase_next          = phase_reg;
        bytes_left_next     = bytes_left_reg;
        result.valid        = 1'b0;
        result.payload_byte = in_byte_reg;
        result.frame_last   = 1'b0;
        result.empty_frame  = 1'b0;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte_reg == SYNC_FIRST)
                    begin
                        phase_next = PH_NEED_AA;
                    end
                end
                PH_NEED_AA:
                begin
                    phase_next = (in_byte_reg == SYNC_SECOND) ? PH_LENGTH : PH_HUNT;
                end
                PH_LENGTH:
                begin
                    if (in_byte_reg > {{(BYTE_W-LEN_W){1'b0}}, limit})
                    begin
                        phase_next = PH_HUNT;
                    end
                    else if (in_byte_reg == '0)
                    begin
                        phase_next          = PH_HUNT;
                        result.valid        = 1'b1;
                        result.payload_byte = '0;
                        result.frame_last   = 1'b1;
                        result.empty_frame  = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = in_byte_reg[LEN_W-1:0];
                        phase_next      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (bytes_left_reg == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        bytes_left_next   = left_dec;
                        result.valid      = 1'b1;
                        result.frame_last = (left_dec == '0);
                        if (left_dec == '0)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            in_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            in_valid_reg   <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

endmodule

// ----- rtl/sld_out_reg.sv -----
// Result register of the deframer; holds an item until the sink takes it.
// Depends on sld_pkg for the result type and widths.
module sld_out_reg
    import sld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_t           result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] payload_byte,
    output logic              frame_last,
    output logic              empty_frame
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] payload_byte_reg;
    logic              frame_last_reg;
    logic              empty_frame_reg;

    // The register can load when it is empty or its item leaves this cycle.
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid_next = out_free ? result.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && result.valid)
        begin
            payload_byte_reg <= result.payload_byte;
            frame_last_reg   <= result.frame_last;
            empty_frame_reg  <= result.empty_frame;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_byte_reg;
    assign frame_last   = frame_last_reg;
    assign empty_frame  = empty_frame_reg;

endmodule

// ----- rtl/sld_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
// Depends on sld_pkg for widths.
module sld_checker
    import sld_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] payload_byte,
    input logic              frame_last,
    input logic              empty_frame,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    // An empty-frame marker always closes its frame.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> frame_last)
        else $error("empty frame marker without frame_last");

    // An empty-frame marker carries a zero byte.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> payload_byte == '0)
        else $error("empty frame marker with nonzero byte");

    // The readable register never shows bits above the length field.
    a_prdata_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        pready |-> prdata[DATA_W-1:LEN_W] == '0)
        else $error("prdata upper bits set");

    // A stalled result stays presented.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

endmodule

bind sync_length_deframer sld_checker u_sld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .frame_last   (frame_last),
    .empty_frame  (empty_frame),
    .prdata       (prdata),
    .pready       (pready)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sync_length_deframer: directed table, then random framed traffic.
// Depends on sld_pkg for widths, sync bytes and result_t; needs only the RTL.
module tb;
    import sld_pkg::*;

    // Address map: register i sits at byte address 4*i, index 1 is unused.
    localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = ADDR_W'(4 * REG_MAX_LEN);
    localparam logic [ADDR_W-1:0] ADDR_SPARE   = ADDR_W'(4);

    localparam int PHASE_BUDGET  = 232;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 1000;
    localparam int REPORT_MAX    = 10;

    localparam result_t NO_RESULT  = '{valid: 1'b0, payload_byte: 8'h00,
                                       frame_last: 1'b0, empty_frame: 1'b0};
    localparam result_t EMPTY_MARK = '{valid: 1'b1, payload_byte: 8'h00,
                                       frame_last: 1'b1, empty_frame: 1'b1};
    localparam result_t LAST_FF    = '{valid: 1'b1, payload_byte: 8'hFF,
                                       frame_last: 1'b1, empty_frame: 1'b0};

    typedef enum logic [1:0] {SEEK_55, SEEK_AA, READ_LEN, PASS_BYTES} deframe_phase_t;

    // One row of the directed table. When pinned is set, want is the result that
    // the row must give (valid low means none); otherwise the predictor decides.
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              pinned;
        result_t           want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, NO_RESULT},   // plain byte while hunting
        '{8'hAA, 1'b1, NO_RESULT},   // second sync byte alone
        '{8'h55, 1'b1, NO_RESULT},
        '{8'h55, 1'b1, NO_RESULT},   // breaks the sync and is not taken as a new 0x55
        '{8'hAA, 1'b1, NO_RESULT},
        '{8'h02, 1'b1, NO_RESULT},
        '{8'h55, 1'b1, NO_RESULT},
        '{8'hAA, 1'b1, NO_RESULT},
        '{8'h00, 1'b1, EMPTY_MARK},  // zero length gives the empty frame marker
        '{8'h55, 1'b1, NO_RESULT},
        '{8'hAA, 1'b1, NO_RESULT},
        '{8'h21, 1'b1, NO_RESULT},   // one above the limit: dropped
        '{8'h55, 1'b1, NO_RESULT},
        '{8'hAA, 1'b1, NO_RESULT},
        '{8'h01, 1'b1, NO_RESULT},
        '{8'hFF, 1'b1, LAST_FF},     // single byte frame, all ones
        '{8'h55, 1'b1, NO_RESULT},
        '{8'hAA, 1'b1, NO_RESULT},
        '{8'h02, 1'b1, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h55, 1'b1, NO_RESULT},
        '{8'hAA, 1'b1, NO_RESULT},
        '{8'h3F, 1'b1, NO_RESULT}    // largest length the counter holds: dropped
    };

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte    = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              empty_frame;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Side band that travels with rx_byte so the checker knows about pinned rows.
    logic              row_pinned = 1'b0;
    result_t           row_want   = '0;

    // Predictor state: its own copy of the length limit and the parser.
    logic [LEN_W-1:0]  limit_copy = MAX_LEN_RESET;
    deframe_phase_t    parse_st   = SEEK_55;
    logic [LEN_W-1:0]  left_cnt   = '0;

    result_t           frame_bytes_q[$];
    int                fail_count  = 0;
    int                idle_cycles = 0;
    int                stall_run   = 0;
    bit                in_quiet    = 1'b0;

    sync_length_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .payload_byte(payload_byte),
        .frame_last  (frame_last),
        .empty_frame (empty_frame),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Lengths above the block's frame size are clamped, whatever the register holds.
    function automatic logic [LEN_W-1:0] len_ceiling();
        return (limit_copy > MAX_FRAME_LEN) ? MAX_FRAME_LEN : limit_copy;
    endfunction

    // Advances the predicted parser by one received byte and returns the item it
    // should emit, if any.
    function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
        result_t res;
        res = NO_RESULT;
        case (parse_st)
            SEEK_55:
            begin
                if (b == SYNC_FIRST)
                    parse_st = SEEK_AA;
            end
            SEEK_AA:
            begin
                parse_st = (b == SYNC_SECOND) ? READ_LEN : SEEK_55;
            end
            READ_LEN:
            begin
                if (b > len_ceiling())
                    parse_st = SEEK_55;
                else if (b == 0)
                begin
                    parse_st = SEEK_55;
                    res      = EMPTY_MARK;
                end
                else
                begin
                    left_cnt = b[LEN_W-1:0];
                    parse_st = PASS_BYTES;
                end
            end
            default:
            begin
                if (left_cnt == 0)
                    parse_st = SEEK_55;
                else
                begin
                    left_cnt = left_cnt - 1'b1;
                    res = '{valid: 1'b1, payload_byte: b,
                            frame_last: (left_cnt == 0), empty_frame: 1'b0};
                    if (left_cnt == 0)
                        parse_st = SEEK_55;
                end
            end
        endcase
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < REPORT_MAX)
            $display("tb: mismatch %0d at %0t: %s", fail_count + 1, $realtime, msg);
        fail_count++;
    endtask

    // Checker. Everything is sampled at the rising edge, so all values seen here are
    // the ones that the edge acts on. An accepted input item is run through the
    // predictor at once; an accepted output item is held against the oldest entry.
    always @(posedge clk)
    begin : scoreboard
        result_t pred;
        result_t want;
        logic    busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                busy = 1'b1;
                pred = deframe_byte(rx_byte);
                want = row_pinned ? row_want : pred;
                if (want.valid)
                    frame_bytes_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                if (frame_bytes_q.size() == 0)
                    note_failure($sformatf("unexpected item byte=%02h last=%b empty=%b",
                                           payload_byte, frame_last, empty_frame));
                else
                begin
                    want = frame_bytes_q.pop_front();
                    if (payload_byte !== want.payload_byte ||
                        frame_last   !== want.frame_last   ||
                        empty_frame  !== want.empty_frame)
                        note_failure($sformatf(
                            "expected byte=%02h last=%b empty=%b, got byte=%02h last=%b empty=%b",
                            want.payload_byte, want.frame_last, want.empty_frame,
                            payload_byte, frame_last, empty_frame));
                end
            end
            if (psel && penable && pready)
            begin
                busy = 1'b1;
                if (pwrite && paddr[ADDR_W-1:2] == REG_MAX_LEN)
                    limit_copy = pwdata[LEN_W-1:0];
            end
            idle_cycles <= busy ? 0 : idle_cycles + 1;
        end
    end

    // Output back-pressure: runs of random length, mostly short, with the odd long
    // stall and long stall-free stretches.
    always @(posedge clk)
    begin : sink_pressure
        int r;
        if (stall_run != 0)
            stall_run <= stall_run - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 3);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(20, 60);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(8, 30);
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_quiet || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 96)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Presents one item and returns once it has been taken. Valid stays high from
    // one item to the next unless a gap is drawn.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic pinned = 1'b0,
                             input result_t want = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        rx_byte    <= b;
        row_pinned <= pinned;
        row_want   <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] a, output logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stops the input and waits until every predicted item has come out, then lets
    // the pipeline run empty, since header bytes leave nothing behind to wait for.
    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            while (frame_bytes_q.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (frame_bytes_q.size() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return SYNC_FIRST;
        else if (r < 20)
            return SYNC_SECOND;
        else if (r < 25)
            return 8'h00;
        else if (r < 30)
            return 8'hFF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_length(input int m);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 22)
            return m;
        else if (r < 30)
            return m + 1;
        else if (r < 38)
            return $urandom_range(m + 1, 255);
        else if (r < 48)
            return $urandom_range(0, m);
        return $urandom_range(0, (m < 8) ? m : 8);
    endfunction

    // Mostly well-formed frames with random content; the rest is line noise and
    // sync pairs that break after the first byte. Noise does not count to the budget.
    task automatic random_frames(input int budget);
        int sent;
        int m;
        int len;
        int r;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 4)
                in_quiet = !in_quiet;
            m = len_ceiling();
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            else if (r < 20)
            begin
                b = BYTE_W'($urandom_range(0, 255));
                if (b == SYNC_SECOND)
                    b = SYNC_FIRST;
                send_byte(SYNC_FIRST);
                send_byte(b);
                sent += 2;
            end
            else
            begin
                len = pick_length(m);
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(BYTE_W'(len));
                sent += 3;
                if (len <= m)
                begin
                    repeat (len)
                        send_byte(pick_payload());
                    sent += len;
                end
            end
        end
    endtask

    // Reconfigures while the block is idle, reads the limit back, then runs traffic.
    task automatic change_limit(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] rd;
        settle();
        apb_write(a, d);
        apb_read(ADDR_MAX_LEN, rd);
        if (rd !== DATA_W'(limit_copy))
            note_failure($sformatf("limit readback expected %0d, got %0h", limit_copy, rd));
        random_frames(PHASE_BUDGET);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_byte(DIRECTED[i].rx, DIRECTED[i].pinned, DIRECTED[i].want);
        random_frames(PHASE_BUDGET);

        change_limit(ADDR_MAX_LEN, 32'h0000_0000);   // only empty frames get through
        change_limit(ADDR_MAX_LEN, 32'hFFFF_FFFF);   // 63, clamped to the frame size
        change_limit(ADDR_MAX_LEN, 32'h0000_0001);
        change_limit(ADDR_SPARE, $urandom());        // unused index: limit stays at 1
        change_limit(ADDR_MAX_LEN, $urandom());
        change_limit(ADDR_MAX_LEN, 32'h0000_0020);

        settle();
        if (frame_bytes_q.size() != 0)
            note_failure($sformatf("%0d items never came out", frame_bytes_q.size()));
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
